@@ sv/tpne_pkg.sv @@
`default_nettype none
package tpne_pkg;

  localparam int NUM_CHANNELS = 64;
  localparam int CHAN_W       = 6;
  localparam int RAM_AW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;
  localparam int LVL_W        = 3;

  localparam logic [7:0] BYTE_ROW_END  = 8'h00;
  localparam logic [7:0] ROW_MAX       = 8'hff;
  localparam int         BIT_NEW_MASK  = 7;
  localparam int         BIT_NOTE      = 0;
  localparam int         BIT_INST      = 1;
  localparam int         BIT_VOL       = 2;
  localparam int         BIT_CMD       = 3;
  localparam int         BIT_REP_NOTE  = 4;

  typedef enum logic [2:0] {
    PH_CHAN = 3'd0,
    PH_MASK = 3'd1,
    PH_NOTE = 3'd2,
    PH_INST = 3'd3,
    PH_VOL  = 3'd4,
    PH_CMD  = 3'd5,
    PH_CVAL = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] delta_rows;
    logic [7:0] note;
    logic       last;
  } result_t;

  typedef struct packed {
    logic    first;
    logic    second;
    result_t item0;
    result_t item1;
  } push_t;

  typedef struct packed {
    logic              en;
    logic [CHAN_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

  typedef struct packed {
    logic held;
    logic fire;
  } stat_t;

  function automatic logic chan_ok(input logic [CHAN_W-1:0] c);
    return ({1'b0, c} < (CHAN_W + 1)'(NUM_CHANNELS));
  endfunction

  // First field phase after 'from' that the mask asks for; PH_CHAN when none.
  function automatic phase_t phase_after(input phase_t from, input logic [7:0] mask);
    phase_t ph;
    if (from < PH_NOTE && mask[BIT_NOTE]) ph = PH_NOTE;
    else if (from < PH_INST && mask[BIT_INST]) ph = PH_INST;
    else if (from < PH_VOL && mask[BIT_VOL]) ph = PH_VOL;
    else if (from < PH_CMD && mask[BIT_CMD]) ph = PH_CMD;
    else ph = PH_CHAN;
    return ph;
  endfunction

endpackage
`default_nettype wire

@@ sv/tpne_chan_ram.sv @@
`default_nettype none
module tpne_chan_ram (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       rd_en,
  input  wire [tpne_pkg::CHAN_W-1:0] rd_addr,
  output logic [7:0]                rd_data,
  input  tpne_pkg::wr_t             wr
);
  import tpne_pkg::*;

  logic [7:0]              mem [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] valid;
  logic [7:0]              mem_q;
  logic                    hit_q;
  logic                    fwd_q;
  logic [7:0]              fwd_data;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[RAM_AW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      mem_q    <= mem[rd_addr[RAM_AW-1:0]];
      fwd_data <= wr.data;
    end
  end

  // Valid bits stand in for the all-zero reset; forward a same-cycle write.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      hit_q <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr[RAM_AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        hit_q <= valid[rd_addr[RAM_AW-1:0]];
        fwd_q <= wr.en && (wr.addr == rd_addr);
      end
    end
  end

  assign rd_data = fwd_q ? fwd_data : (hit_q ? mem_q : 8'h00);

endmodule
`default_nettype wire

@@ sv/tpne_out_fifo.sv @@
`default_nettype none
module tpne_out_fifo (
  input  wire                       clk,
  input  wire                       rst,
  input  tpne_pkg::push_t           push,
  output logic                      room,
  output logic [tpne_pkg::LVL_W-1:0] level,
  output logic                      out_valid,
  input  wire                       out_ready,
  output tpne_pkg::result_t         out_item
);
  import tpne_pkg::*;

  result_t            slots [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp;
  logic [FIFO_AW-1:0] rp;
  logic               pop;
  logic [LVL_W-1:0]   n_push;

  assign out_valid = (level != '0);
  assign out_item  = slots[rp];
  assign pop       = out_valid && out_ready;
  assign room      = (level <= LVL_W'(FIFO_DEPTH - 2));
  assign n_push    = LVL_W'(push.first) + LVL_W'(push.second);

  always_ff @(posedge clk) begin
    if (push.first) begin
      slots[wp] <= push.item0;
    end
    if (push.second) begin
      slots[wp + FIFO_AW'(1)] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      wp    <= wp + n_push[FIFO_AW-1:0];
      rp    <= rp + FIFO_AW'(pop);
      level <= level + n_push - LVL_W'(pop);
    end
  end

endmodule
`default_nettype wire

@@ sv/tpne_parser.sv @@
`default_nettype none
module tpne_parser (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire [7:0]                 in_byte,
  input  wire                       in_start,
  input  wire [tpne_pkg::CHAN_W-1:0] target_channel,
  input  wire [7:0]                 rd_mask,
  input  wire [7:0]                 rd_note,
  input  wire                       room,
  output tpne_pkg::push_t           push,
  output tpne_pkg::wr_t             wr_mask,
  output tpne_pkg::wr_t             wr_note,
  output tpne_pkg::stat_t           status
);
  import tpne_pkg::*;

  logic              b_valid;
  logic [7:0]        b_byte;
  logic              b_start;
  phase_t            phase;
  phase_t            phase_next;
  logic [CHAN_W-1:0] cur_ch;
  logic [CHAN_W-1:0] cur_ch_next;
  logic [7:0]        cur_mask;
  logic [7:0]        cur_mask_next;
  logic [7:0]        cur_note;
  logic [7:0]        cur_note_next;
  logic [7:0]        row_count;
  logic [7:0]        row_count_next;
  logic [7:0]        last_event_row;
  logic [7:0]        last_event_row_next;

  logic              fire;
  phase_t            ph_eff;
  logic [7:0]        row_eff;
  logic [7:0]        ler_eff;
  logic [CHAN_W-1:0] byte_ch;
  logic [7:0]        rd_mask_ok;
  logic [7:0]        rd_note_ok;
  logic              do_after;
  phase_t            after_from;
  logic [7:0]        after_mask;
  phase_t            after_ph;
  logic [CHAN_W-1:0] entry_ch;
  logic [7:0]        rep_note;
  logic              emit_new;
  logic              emit_rep;
  logic [7:0]        delta0;

  assign fire     = b_valid && room;
  assign in_ready = !rst && (!b_valid || fire);
  assign status   = '{held: b_valid, fire: fire};

  assign ph_eff     = b_start ? PH_CHAN : phase;
  assign row_eff    = b_start ? 8'h00 : row_count;
  assign ler_eff    = b_start ? 8'h00 : last_event_row;
  assign byte_ch    = CHAN_W'(b_byte - 8'd1);
  assign rd_mask_ok = chan_ok(byte_ch) ? rd_mask : 8'h00;
  assign rd_note_ok = chan_ok(byte_ch) ? rd_note : 8'h00;
  assign after_ph   = phase_after(after_from, after_mask);
  assign delta0     = row_eff - ler_eff;

  // Decode which field comes after this byte and what the entry's last note is.
  always_comb begin
    do_after   = 1'b0;
    after_from = PH_MASK;
    after_mask = cur_mask;
    entry_ch   = cur_ch;
    rep_note   = cur_note;
    case (ph_eff)
      PH_CHAN: begin
        entry_ch   = byte_ch;
        after_mask = rd_mask_ok;
        rep_note   = rd_note_ok;
        do_after   = (b_byte != BYTE_ROW_END) && !b_byte[BIT_NEW_MASK];
      end
      PH_MASK: begin
        after_mask = b_byte;
        do_after   = 1'b1;
      end
      PH_NOTE: begin
        after_from = PH_NOTE;
        rep_note   = chan_ok(cur_ch) ? b_byte : 8'h00;
        do_after   = 1'b1;
      end
      PH_INST: begin
        after_from = PH_INST;
        do_after   = 1'b1;
      end
      PH_VOL: begin
        after_from = PH_VOL;
        do_after   = 1'b1;
      end
      PH_CVAL: begin
        after_from = PH_CMD;
        do_after   = 1'b1;
      end
      default: begin
        do_after = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    phase_next          = phase;
    cur_ch_next         = cur_ch;
    cur_mask_next       = cur_mask;
    cur_note_next       = cur_note;
    row_count_next      = row_eff;
    last_event_row_next = (emit_new || emit_rep) ? row_eff : ler_eff;
    case (ph_eff)
      PH_CHAN: begin
        if (b_byte == BYTE_ROW_END) begin
          phase_next = PH_CHAN;
          if (row_eff != ROW_MAX) begin
            row_count_next = row_eff + 8'd1;
          end
        end else begin
          cur_ch_next   = byte_ch;
          cur_note_next = rd_note_ok;
          if (b_byte[BIT_NEW_MASK]) begin
            phase_next = PH_MASK;
          end else begin
            cur_mask_next = rd_mask_ok;
            phase_next    = after_ph;
          end
        end
      end
      PH_MASK: begin
        cur_mask_next = b_byte;
        phase_next    = after_ph;
      end
      PH_NOTE: begin
        cur_note_next = rep_note;
        phase_next    = after_ph;
      end
      PH_CMD: begin
        phase_next = PH_CVAL;
      end
      PH_INST, PH_VOL, PH_CVAL: begin
        phase_next = after_ph;
      end
      default: begin
        phase_next = PH_CHAN;
      end
    endcase
  end

  // Outputs: results and table writes.
  always_comb begin
    emit_new = (ph_eff == PH_NOTE) && (cur_ch == target_channel);
    emit_rep = do_after && (after_ph == PH_CHAN) && after_mask[BIT_REP_NOTE] &&
               (entry_ch == target_channel);

    wr_mask      = '{en: 1'b0, addr: cur_ch, data: b_byte};
    wr_note      = '{en: 1'b0, addr: cur_ch, data: b_byte};
    wr_mask.en   = fire && (ph_eff == PH_MASK) && chan_ok(cur_ch);
    wr_note.en   = fire && (ph_eff == PH_NOTE) && chan_ok(cur_ch);

    push.first  = fire && (emit_new || emit_rep);
    push.second = fire && emit_new && emit_rep;
    push.item0  = '{delta_rows: delta0, note: emit_new ? b_byte : rep_note,
                    last: !(emit_new && emit_rep)};
    push.item1  = '{delta_rows: 8'h00, note: rep_note, last: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      b_byte  <= in_byte;
      b_start <= in_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid        <= 1'b0;
      phase          <= PH_CHAN;
      cur_ch         <= '0;
      cur_mask       <= 8'h00;
      cur_note       <= 8'h00;
      row_count      <= 8'h00;
      last_event_row <= 8'h00;
    end else begin
      if (in_ready) begin
        b_valid <= in_valid;
      end
      if (fire) begin
        phase          <= phase_next;
        cur_ch         <= cur_ch_next;
        cur_mask       <= cur_mask_next;
        cur_note       <= cur_note_next;
        row_count      <= row_count_next;
        last_event_row <= last_event_row_next;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/tracker_pattern_note_extractor.sv @@
`default_nettype none
// Channel   Dir  Fields
// s_*       in   tdata = data_byte[7:0]; tuser = pattern_start
// m_*       out  tdata = delta_rows[7:0], note[15:8]; tlast = last
// cfg_*     in   cfg_wdata = target_channel, written when cfg_we is high
//
// One byte a cycle unless stalled: the transfer registers the byte and reads
// the per-channel mask and last-note RAMs; the parser then uses the read data.
// A byte gives zero to two results; they queue in a four-entry FIFO drained
// one a cycle while m_tready is high.
// The input stalls while the FIFO has fewer than two free slots.
// Reset clears parse state and the RAM valid bits at once; no clearing pass.
module tracker_pattern_note_extractor (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [7:0]  s_tdata,   // data_byte[7:0]
  input  wire        s_tuser,   // pattern_start
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [15:0] m_tdata,  // delta_rows[7:0], note[15:8]
  output logic       m_tlast,
  input  wire        cfg_we,
  input  wire [5:0]  cfg_wdata
);
  import tpne_pkg::*;

  logic [CHAN_W-1:0] target_channel;
  logic [CHAN_W-1:0] rd_addr;
  logic              rd_en;
  logic [7:0]        rd_mask;
  logic [7:0]        rd_note;
  wr_t               wr_mask;
  wr_t               wr_note;
  push_t             push;
  stat_t             status;
  logic              room;
  logic [LVL_W-1:0]  level;
  result_t           out_item;

  // Hold the target channel; the user must write it only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_channel <= '0;
    end else if (cfg_we) begin
      target_channel <= cfg_wdata;
    end
  end

  // Read both tables for the channel a channel byte would name; the parser
  // uses the data only when the byte turns out to be a channel byte.
  assign rd_en   = s_tvalid && s_tready;
  assign rd_addr = CHAN_W'(s_tdata - 8'd1);

  tpne_chan_ram u_mask_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_mask),
    .wr      (wr_mask)
  );

  tpne_chan_ram u_note_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_note),
    .wr      (wr_note)
  );

  tpne_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_byte        (s_tdata),
    .in_start       (s_tuser),
    .target_channel (target_channel),
    .rd_mask        (rd_mask),
    .rd_note        (rd_note),
    .room           (room),
    .push           (push),
    .wr_mask        (wr_mask),
    .wr_note        (wr_note),
    .status         (status)
  );

  tpne_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .level     (level),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = {out_item.note, out_item.delta_rows};
  assign m_tlast = out_item.last;

  // FIFO never overfills.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(FIFO_DEPTH))
    else $error("output FIFO overflow");

  // A parked byte is not dropped while the FIFO lacks room for two results.
  a_stall_keeps: assert property (@(posedge clk) disable iff (rst)
    status.held && !status.fire |=> status.held)
    else $error("stalled byte lost");

  // Two results from one byte: only the second carries last.
  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    push.second |-> push.first && !push.item0.last && push.item1.last)
    else $error("bad last marking on result pair");

  // Table writes happen only when the parser retires a byte.
  a_write_on_fire: assert property (@(posedge clk) disable iff (rst)
    (wr_mask.en || wr_note.en) |-> status.fire)
    else $error("table write without retire");

endmodule
`default_nettype wire

@@ tb/tracker_pattern_note_extractor_checker.sv @@
`timescale 1ns / 1ps

module tracker_pattern_note_extractor_checker (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  input  wire        s_tready,
  input  wire [7:0]  s_tdata,   // data_byte[7:0]
  input  wire        s_tuser,   // pattern_start
  input  wire        m_tvalid,
  input  wire        m_tready,
  input  wire [15:0] m_tdata,   // delta_rows[7:0], note[15:8]
  input  wire        m_tlast,
  input  wire        cfg_we,
  input  wire [5:0]  cfg_wdata,
  output int         fail_count,
  output int         pending
);
  import tpne_pkg::*;

  // Mirror of the decoder state; tables are sized for the full 6-bit channel field.
  logic [5:0] sel_chan;
  phase_t     phase;
  logic [5:0] cur_chan;
  logic [7:0] cur_mask;
  logic [7:0] mask_tab [64];
  logic [7:0] note_tab [64];
  logic [7:0] rows;
  logic [7:0] event_row;

  result_t    byte_out [2];
  int         byte_cnt;
  result_t    pending_notes [$];
  int         errors = 0;

  function automatic bit in_range(input logic [5:0] c);
    return int'(c) < NUM_CHANNELS;
  endfunction

  task automatic log_failure(input string text);
    errors++;
    if (errors <= 10) $display("%t %s", $realtime, text);
  endtask

  task automatic note_on(input logic [7:0] n);
    byte_out[byte_cnt].delta_rows = rows - event_row;
    byte_out[byte_cnt].note       = n;
    byte_out[byte_cnt].last       = 1'b0;
    byte_cnt++;
    event_row = rows;
  endtask

  // Step to the next field the mask asks for; with none left, close the entry.
  task automatic close_field(input phase_t from);
    bit     found;
    phase_t cand;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      cand = phase_t'(PH_NOTE + i);
      if (!found && cand > from && cur_mask[BIT_NOTE + i]) begin
        phase = cand;
        found = 1'b1;
      end
    end
    if (!found) begin
      phase = PH_CHAN;
      if (cur_mask[BIT_REP_NOTE] && cur_chan == sel_chan)
        note_on(in_range(cur_chan) ? note_tab[cur_chan] : 8'h00);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic st);
    logic [7:0] prev;
    byte_cnt = 0;
    if (st) begin
      rows      = 8'h00;
      event_row = 8'h00;
      phase     = PH_CHAN;
    end
    case (phase)
      PH_CHAN: begin
        if (b == BYTE_ROW_END) begin
          if (rows != ROW_MAX) rows++;
        end else begin
          prev     = b - 8'd1;
          cur_chan = prev[5:0];
          if (b[BIT_NEW_MASK]) begin
            phase = PH_MASK;
          end else begin
            cur_mask = in_range(cur_chan) ? mask_tab[cur_chan] : 8'h00;
            close_field(PH_MASK);
          end
        end
      end
      PH_MASK: begin
        cur_mask = b;
        if (in_range(cur_chan)) mask_tab[cur_chan] = b;
        close_field(PH_MASK);
      end
      PH_NOTE: begin
        if (in_range(cur_chan)) note_tab[cur_chan] = b;
        if (cur_chan == sel_chan) note_on(b);
        close_field(PH_NOTE);
      end
      PH_INST: close_field(PH_INST);
      PH_VOL:  close_field(PH_VOL);
      PH_CMD:  phase = PH_CVAL;
      PH_CVAL: close_field(PH_CMD);
      default: phase = PH_CHAN;
    endcase
    if (byte_cnt > 0) byte_out[byte_cnt - 1].last = 1'b1;
    for (int i = 0; i < byte_cnt; i++) pending_notes.push_back(byte_out[i]);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      sel_chan  = 6'd0;
      phase     = PH_CHAN;
      cur_chan  = 6'd0;
      cur_mask  = 8'h00;
      rows      = 8'h00;
      event_row = 8'h00;
      for (int i = 0; i < 64; i++) begin
        mask_tab[i] = 8'h00;
        note_tab[i] = 8'h00;
      end
      pending_notes.delete();
    end else begin
      if (cfg_we) sel_chan = cfg_wdata;
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        if (pending_notes.size() == 0) begin
          log_failure($sformatf("unexpected result: delta %0d note %0d last %0d",
                                m_tdata[7:0], m_tdata[15:8], m_tlast));
        end else begin
          want = pending_notes.pop_front();
          if (want.delta_rows !== m_tdata[7:0] || want.note !== m_tdata[15:8] ||
              want.last !== m_tlast)
            log_failure($sformatf({"result mismatch: expected delta %0d note %0d last %0d,",
                                   " got delta %0d note %0d last %0d"},
                                  want.delta_rows, want.note, want.last,
                                  m_tdata[7:0], m_tdata[15:8], m_tlast));
        end
      end
    end
    pending    <= pending_notes.size();
    fail_count <= errors;
  end

endmodule

@@ tb/tracker_pattern_note_extractor_tb.sv @@
`timescale 1ns / 1ps

module tracker_pattern_note_extractor_tb;
  import tpne_pkg::*;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;   // data_byte[7:0]
  logic        s_tuser   = 1'b0;    // pattern_start
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;             // delta_rows[7:0], note[15:8]
  logic        m_tlast;
  logic        cfg_we    = 1'b0;
  logic [5:0]  cfg_wdata = 6'd0;

  int          fail_count;
  int          pending;

  // Stimulus-side bookkeeping. The generator tracks each channel's mask so it
  // can emit entries that reuse a stored mask and still stay well formed.
  logic [7:0]  gen_mask [64];
  logic [5:0]  target     = 6'd0;
  logic        idle_on    = 1'b1;
  logic        hold_req   = 1'b0;
  bit          need_start = 1'b0;
  int          items_sent = 0;

  // Receiver-side counters.
  int          stall_left;
  int          hold_left;
  bit          hold_done;

  tracker_pattern_note_extractor u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  tracker_pattern_note_extractor_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stall bursts while idling is on, plus one long hold-off
  // on request so the output FIFO fills and s_tready drops.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
      hold_done  <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_tready  <= 1'b0;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offer one byte and hold it until the transfer. A pending resync request
  // forces pattern_start on this byte.
  task automatic send_byte(input logic [7:0] b, input logic st);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= b;
    s_tuser    <= st | need_start;
    need_start = 1'b0;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Mostly random notes, with the two extremes showing up often.
  function automatic logic [7:0] pick_note();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // Emit one well-formed entry: channel byte, optional mask byte, then the
  // data bytes that the mask in force calls for.
  task automatic send_entry(input logic [5:0] ch, input bit fresh, input logic [7:0] m_in,
                            input logic [7:0] note_val, input logic st);
    logic [7:0] code;
    logic [7:0] m;
    code = {fresh, 1'($urandom_range(0, 1)), 6'(ch + 6'd1)};
    // A plain code of zero would end the row; bit 6 selects the same channel.
    if (code == BYTE_ROW_END) code[6] = 1'b1;
    send_byte(code, st);
    if (fresh) begin
      send_byte(m_in, 1'b0);
      gen_mask[ch] = m_in;
    end
    m = gen_mask[ch];
    if (m[BIT_NOTE]) send_byte(note_val, 1'b0);
    if (m[BIT_INST]) send_byte(8'($urandom), 1'b0);
    if (m[BIT_VOL])  send_byte(8'($urandom), 1'b0);
    if (m[BIT_CMD]) begin
      send_byte(8'($urandom), 1'b0);
      send_byte(8'($urandom), 1'b0);
    end
  endtask

  // Drop valid, wait for every expected result, then allow for bytes still in
  // flight that produce nothing. Bounded so a stuck block falls to the verdict.
  task automatic wait_drained();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_target(input logic [5:0] ch);
    cfg_we    <= 1'b1;
    cfg_wdata <= ch;
    target    = ch;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random traffic: mostly entries (half on the target channel), row ends,
  // truncated entries that resync with pattern_start, and raw noise.
  task automatic run_segment(input int quota, input bit with_hold, input bit with_silence);
    int         base;
    int         pick;
    bit         silence_done;
    logic [5:0] ch;
    logic [7:0] m;
    base         = items_sent;
    silence_done = 1'b0;
    while (items_sent - base < quota) begin
      if (with_hold && items_sent - base >= 60) hold_req <= 1'b1;
      if (with_silence && !silence_done && items_sent - base >= 100) begin
        // Run the row counter past its ceiling so delta_rows saturates.
        repeat (270) send_byte(BYTE_ROW_END, 1'b0);
        silence_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      ch   = $urandom_range(0, 1) ? target : 6'($urandom);
      m    = 8'($urandom);
      if ($urandom_range(0, 1)) m[BIT_NOTE] = 1'b1;
      if (pick < 60) begin
        send_entry(ch, 1'($urandom_range(0, 1)), m, pick_note(),
                   1'($urandom_range(0, 49) == 0));
      end else if (pick < 80) begin
        send_byte(BYTE_ROW_END, 1'($urandom_range(0, 29) == 0));
      end else if (pick < 88) begin
        // Cut an entry short and restart the pattern on the next byte.
        send_byte({1'b1, 1'($urandom_range(0, 1)), 6'(ch + 6'd1)}, 1'b0);
        m[3:0] = m[3:0] | 4'b0001;
        send_byte(m, 1'b0);
        gen_mask[ch] = m;
        if ($urandom_range(0, 1)) send_byte(pick_note(), 1'b0);
        need_start = 1'b1;
      end else begin
        send_byte(8'($urandom), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1)) need_start = 1'b1;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 64; i++) gen_mask[i] = 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_target(6'd0);

    // Directed part, target channel 0.
    send_byte(BYTE_ROW_END, 1'b1);                     // row end on the pattern start
    send_entry(6'd0, 1'b1, 8'h01, 8'h00, 1'b0);        // new note, lowest value
    send_entry(6'd0, 1'b1, 8'h11, 8'hff, 1'b0);        // note then its repeat, same byte
    send_entry(6'd0, 1'b0, 8'h00, 8'h7f, 1'b0);        // stored mask reused
    send_entry(6'd0, 1'b1, 8'h10, 8'h00, 1'b0);        // repeat given on the mask byte
    send_entry(6'd0, 1'b0, 8'h00, 8'h00, 1'b0);        // repeat given on the channel byte
    send_entry(6'd0, 1'b1, 8'hff, 8'h80, 1'b0);        // every field; repeat on command value
    send_entry(6'd5, 1'b1, 8'h09, 8'h3c, 1'b0);        // other channel stays silent
    send_byte(8'h81, 1'b0);                            // channel 0 with new mask
    send_byte(8'h01, 1'b0);                            // note expected next...
    send_entry(6'd0, 1'b1, 8'h01, 8'h40, 1'b1);        // ...but the pattern restarts

    // Random phases over several target settings, both extremes included.
    // The last phase runs with no idling on either side.
    for (int p = 0; p < 4; p++) begin
      wait_drained();
      case (p)
        0:       set_target(6'd63);
        1:       set_target(6'($urandom_range(1, 62)));
        2:       set_target(6'd0);
        default: set_target(6'($urandom_range(1, 62)));
      endcase
      if (p == 3) idle_on <= 1'b0;
      run_segment(340, p == 1, p == 2);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("tracker_pattern_note_extractor_tb passed");
    end else begin
      $display("tracker_pattern_note_extractor_tb failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("tracker_pattern_note_extractor_tb failed");
    $finish;
  end

endmodule

@@ files.f @@
sv/tpne_pkg.sv
sv/tpne_chan_ram.sv
sv/tpne_out_fifo.sv
sv/tpne_parser.sv
sv/tracker_pattern_note_extractor.sv
tb/tracker_pattern_note_extractor_checker.sv
tb/tracker_pattern_note_extractor_tb.sv
